FILE: hw/rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, limits and codes for the LFU slot replacement core.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Port field widths
    localparam int CAND_W     = 7;
    localparam int SLOT_OUT_W = 4;
    localparam int OUTC_W     = 2;
    localparam int EVICT_W    = 7;
    localparam int CFG_W      = 5;

    // Number of distinct candidate codes on the input field
    localparam int CAND_RANGE = 1 << CAND_W;

    // Stored value widths and saturation limits
    localparam int COUNT_W = 16;
    localparam int TIME_W  = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

    // Active slot register value after reset
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Outcome codes reported with each result
    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT     = 2'd0,
        OUT_FREE    = 2'd1,
        OUT_REPLACE = 2'd2
    } t_outcome;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_INC,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

FILE: hw/rtl/lfu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lfu_slot_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_slot_replacement_core
// Least-frequently-used slot replacement with oldest-insertion tie break.
// Per-identifier access counts and insertion times live in RAM, as do the
// slot owners; each access is resolved by one pipelined scan of the slots.
//
//   channel   | direction | handshake                     | payload
//   ----------+-----------+-------------------------------+---------------------
//   access    | in        | start & !busy                 | i_candidate_id
//   result    | out       | o_result_valid (1-cycle pulse)| o_slot_index,
//             |           |                               | o_outcome, o_evicted_id
//   config    | in        | i_cfg_valid & o_cfg_ready     | i_cfg_data
//
// An access keeps busy high through the count increment, the slot scan (owner
// RAM read, then count and time RAM reads, then compare) and the commit.
// The result pulses the cycle after commit. Reset starts a clearing pass over
// all ID_COUNT count entries with busy high; config transfers are always taken.
// The result receiver cannot stall.
// ----------------------------------------------------------------------------
module lfu_slot_replacement_core #(
    parameter int SLOTS    = 16,
    parameter int ID_COUNT = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // access command
    input  logic                            start,
    output logic                            busy,
    input  logic [lfu_pkg::CAND_W-1:0]      i_candidate_id,
    // result
    output logic                            o_result_valid,
    output logic [lfu_pkg::SLOT_OUT_W-1:0]  o_slot_index,
    output logic [lfu_pkg::OUTC_W-1:0]      o_outcome,
    output logic [lfu_pkg::EVICT_W-1:0]     o_evicted_id,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0]       i_cfg_data
);

    import lfu_pkg::*;

    localparam int ID_W   = $clog2(ID_COUNT);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Identifier reduction table: candidate code modulo ID_COUNT
    typedef logic [CAND_RANGE-1:0][ID_W-1:0] t_mod_tbl;

    function automatic t_mod_tbl build_mod_tbl();
        t_mod_tbl tbl;
        for (int i = 0; i < CAND_RANGE; i++) begin
            tbl[i] = ID_W'(i % ID_COUNT);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod_tbl();

    // State and control registers
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_active_slots;
    logic [TIME_W-1:0]  r_access_num;
    logic [ID_W-1:0]    r_clr_addr;
    logic               r_slot_valid [SLOTS];
    logic [CNT_W-1:0]   r_ia;
    logic               r_p1_vld;
    logic               r_p2_vld;
    logic               r_hit;
    logic               r_free;
    logic               r_have_best;
    logic               r_out_vld;

    // Payload registers
    logic [ID_W-1:0]    r_id;
    logic [CNT_W-1:0]   r_n;
    logic [SLOT_W-1:0]  r_p1_idx;
    logic [SLOT_W-1:0]  r_p2_idx;
    logic [ID_W-1:0]    r_p2_owner;
    logic [SLOT_W-1:0]  r_hit_idx;
    logic [SLOT_W-1:0]  r_free_idx;
    logic [SLOT_W-1:0]  r_best_idx;
    logic [ID_W-1:0]    r_best_owner;
    logic [COUNT_W-1:0] r_best_cnt;
    logic [TIME_W-1:0]  r_best_time;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    t_outcome           r_out_outcome;
    logic [EVICT_W-1:0] r_out_evicted;

    // RAM ports
    logic               cnt_we, cnt_re;
    logic [ID_W-1:0]    cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
    logic               tim_we;
    logic [TIME_W-1:0]  tim_rdata;
    logic               own_we;
    logic [ID_W-1:0]    own_rdata;

    // Combinational helpers
    logic [CNT_W-1:0]   n_eff;
    logic               issue;
    logic               take_best;
    logic [SLOT_W-1:0]  fin_slot;
    t_outcome           fin_outcome;
    logic [COUNT_W-1:0] cnt_inc;

    // Active slot count, clamped to 1..SLOTS
    always_comb begin
        if (r_active_slots == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(r_active_slots) > SLOTS) begin
            n_eff = CNT_W'(SLOTS);
        end else begin
            n_eff = CNT_W'(r_active_slots);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign issue       = (r_state == S_SCAN) && (r_ia < r_n);
    assign cnt_inc     = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;

    // Victim compare: smaller count wins, then earlier insertion, else lower slot
    assign take_best = !r_have_best || (r_best_cnt > cnt_rdata) ||
                       ((r_best_cnt == cnt_rdata) && (r_best_time > tim_rdata));

    // Commit decision
    always_comb begin
        if (r_hit) begin
            fin_slot    = r_hit_idx;
            fin_outcome = OUT_HIT;
        end else if (r_free) begin
            fin_slot    = r_free_idx;
            fin_outcome = OUT_FREE;
        end else begin
            fin_slot    = r_best_idx;
            fin_outcome = OUT_REPLACE;
        end
    end

    // Next state and RAM controls
    always_comb begin
        n_state   = r_state;
        cnt_we    = 1'b0;
        cnt_waddr = r_id;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = own_rdata;
        tim_we    = 1'b0;
        own_we    = 1'b0;
        case (r_state)
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr_addr;
                if (r_clr_addr == ID_W'(ID_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cnt_re    = 1'b1;
                cnt_raddr = MOD_TBL[i_candidate_id];
                if (start) begin
                    n_state = S_INC;
                end
            end
            S_INC: begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_inc;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                cnt_re = r_p1_vld;
                if (!issue && !r_p1_vld) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                own_we = (fin_outcome != OUT_HIT);
                tim_we = (fin_outcome != OUT_HIT);
                if (fin_outcome == OUT_REPLACE) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_best_owner;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= CFG_RESET;
            r_access_num   <= '0;
            r_clr_addr     <= '0;
            r_ia           <= '0;
            r_p1_vld       <= 1'b0;
            r_p2_vld       <= 1'b0;
            r_hit          <= 1'b0;
            r_free         <= 1'b0;
            r_have_best    <= 1'b0;
            r_out_vld      <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else begin
            // config transfer
            if (i_cfg_valid) begin
                r_active_slots <= i_cfg_data;
            end
            // clearing pass address
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // scan pipeline
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            if (r_state == S_INC) begin
                r_ia        <= '0;
                r_hit       <= 1'b0;
                r_free      <= 1'b0;
                r_have_best <= 1'b0;
            end
            if (issue) begin
                r_ia <= r_ia + 1'b1;
            end
            if (r_p1_vld) begin
                if (!r_hit && r_slot_valid[r_p1_idx] && (own_rdata == r_id)) begin
                    r_hit <= 1'b1;
                end
                if (!r_free && !r_slot_valid[r_p1_idx]) begin
                    r_free <= 1'b1;
                end
            end
            if (r_p2_vld && take_best) begin
                r_have_best <= 1'b1;
            end
            // commit
            if (r_state == S_FIN) begin
                if (fin_outcome != OUT_HIT) begin
                    r_slot_valid[fin_slot] <= 1'b1;
                end
                if (r_access_num != TIME_MAX) begin
                    r_access_num <= r_access_num + 1'b1;
                end
            end
            r_out_vld <= (r_state == S_FIN);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_id <= MOD_TBL[i_candidate_id];
            r_n  <= n_eff;
        end
        r_p1_idx   <= r_ia[SLOT_W-1:0];
        r_p2_idx   <= r_p1_idx;
        r_p2_owner <= own_rdata;
        if (r_p1_vld) begin
            if (!r_hit && r_slot_valid[r_p1_idx] && (own_rdata == r_id)) begin
                r_hit_idx <= r_p1_idx;
            end
            if (!r_free && !r_slot_valid[r_p1_idx]) begin
                r_free_idx <= r_p1_idx;
            end
        end
        if (r_p2_vld && take_best) begin
            r_best_idx   <= r_p2_idx;
            r_best_owner <= r_p2_owner;
            r_best_cnt   <= cnt_rdata;
            r_best_time  <= tim_rdata;
        end
        if (r_state == S_FIN) begin
            r_out_slot    <= SLOT_OUT_W'(fin_slot);
            r_out_outcome <= fin_outcome;
            r_out_evicted <= (fin_outcome == OUT_REPLACE) ? EVICT_W'(r_best_owner) : '0;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_slot_index   = r_out_slot;
    assign o_outcome      = r_out_outcome;
    assign o_evicted_id   = r_out_evicted;

    // Access count store
    lfu_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ID_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Insertion time store
    lfu_ram #(
        .WIDTH (TIME_W),
        .DEPTH (ID_COUNT)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (tim_we),
        .i_waddr (r_id),
        .i_wdata (r_access_num),
        .i_re    (r_p1_vld),
        .i_raddr (own_rdata),
        .o_rdata (tim_rdata)
    );

    // Slot owner store
    lfu_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (fin_slot),
        .i_wdata (r_id),
        .i_re    (issue),
        .i_raddr (r_ia[SLOT_W-1:0]),
        .o_rdata (own_rdata)
    );

`ifndef SYNTHESIS
    // Results are single-cycle pulses; two items never complete back to back
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // Reported outcome is a defined code
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_outcome == OUT_HIT || o_outcome == OUT_FREE ||
                            o_outcome == OUT_REPLACE))
        else $error("undefined outcome code");

    // Evicted identifier only reported on replacement
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_outcome != OUT_REPLACE) |-> (o_evicted_id == '0))
        else $error("evicted identifier set without replacement");

    // An accepted access raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted access");

    // Replacement only with a victim candidate; it occurs only with neither a hit nor a free slot
    a_replace_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && fin_outcome == OUT_REPLACE) |-> r_have_best)
        else $error("replacement without a victim candidate");
`endif

endmodule
